### rtl/gfm_pkg.sv
// Package of the geometric feature merge table.
// Entry and tolerance types, compare result group, control states, constants.
// No dependencies.
package gfm_pkg;

  // three signed 32-bit components
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec3_t;

  // one stored feature (also used for the candidate)
  typedef struct packed {
    logic        kind;
    vec3_t       org;
    vec3_t       dir;
    logic [30:0] radius;
    logic [30:0] extent;
    logic [7:0]  weight;
  } entry_t;

  // tolerance registers
  typedef struct packed {
    logic [19:0] radius_tol;
    logic [19:0] axis_tol;
    logic [30:0] dir_tol;
  } tol_t;

  // result of comparing one table entry against the candidate
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [30:0] extent;  // max of entry and candidate
    logic [7:0]  weight;  // max of entry and candidate
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS_TOL = 2'd0;
  localparam logic [1:0] REG_AXIS_TOL   = 2'd1;
  localparam logic [1:0] REG_DIR_TOL    = 2'd2;

  localparam logic [19:0] RADIUS_TOL_RST = 20'd51;
  localparam logic [19:0] AXIS_TOL_RST   = 20'd102;
  localparam logic [30:0] DIR_TOL_RST    = 31'd10737;

  // compare pipeline depth in stages
  localparam int unsigned CMP_LAT = 5;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [32:0] MAX_POS_S32 = 33'sd2147483647;

  // func codes
  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // kind codes
  localparam logic KIND_CYL   = 1'b0;
  localparam logic KIND_PLANE = 1'b1;

endpackage

### rtl/gfm_cell.sv
// One cell of the rotating feature ring: holds a single table entry.
// Shifts toward the head, loads a new entry or takes a merged extent/weight.
// Depends on gfm_pkg.
module gfm_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  gfm_pkg::entry_t shift_in,
  input  logic            load_en,
  input  gfm_pkg::entry_t load_val,
  input  logic            upd_en,
  input  logic [30:0]     upd_extent,
  input  logic [7:0]      upd_weight,
  output gfm_pkg::entry_t q
);
  import gfm_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // next entry: shift, load or merge update
  always_comb begin
    ent_nxt = ent_r;
    if (shift_en) begin
      ent_nxt = shift_in;
    end else if (load_en) begin
      ent_nxt = load_val;
    end else if (upd_en) begin
      ent_nxt.extent = upd_extent;
      ent_nxt.weight = upd_weight;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q = ent_r;

endmodule

### rtl/gfm_cmp.sv
// Compare pipeline at the head of the ring: one table entry per cycle
// against the held candidate; the result is registered at the end.
// Depends on gfm_pkg.
module gfm_cmp #(
  parameter int unsigned IDX_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gfm_pkg::entry_t    cand,
  input  gfm_pkg::tol_t      tol,
  input  logic               ent_vld,
  input  logic [IDX_W-1:0]   ent_idx,
  input  gfm_pkg::entry_t    ent,
  output gfm_pkg::cmp_res_t  res,
  output logic [IDX_W-1:0]   res_idx
);
  import gfm_pkg::*;

  // valid and index travel alongside the data
  logic [CMP_LAT-1:0] vld_r;
  logic [IDX_W-1:0]   idx_r [CMP_LAT];
  logic [30:0]        ext_r [CMP_LAT];
  logic [7:0]         wt_r  [CMP_LAT];
  logic [CMP_LAT-1:0] kind_ok_r;
  logic [CMP_LAT-1:0] rad_ok_r;
  logic [CMP_LAT-1:0] plane_r;

  // stage 1: differences
  logic signed [32:0] dx_r, dy_r, dz_r;
  vec3_t              ed_r;
  logic signed [31:0] rdiff;
  logic signed [31:0] rtol_s;

  // stage 2: products
  logic signed [64:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [64:0] p_xx_r, p_yy_r, p_zz_r;
  logic signed [63:0] q_x_r, q_y_r, q_z_r;

  // stage 3: floored sums
  logic signed [65:0] cs0, cs1, cs2, ds;
  logic signed [66:0] ps;
  logic signed [35:0] c0_r, c1_r, c2_r, dd_r;
  logic signed [36:0] pd_r;

  // stage 4: bounds and squares
  logic signed [36:0] atol_s;
  logic signed [37:0] dtol_s;
  logic signed [35:0] ca0, ca1, ca2, dabs;
  logic signed [36:0] ddiff;
  logic [39:0]        sq0_r, sq1_r, sq2_r, tol2_r;
  logic               c_ok_r, plane_ok_r, dir_ok_r;

  // stage 5
  logic [41:0] sq_sum;
  logic        hit_r;

  assign rdiff  = $signed({1'b0, ent.radius}) - $signed({1'b0, cand.radius});
  assign rtol_s = $signed({12'b0, tol.radius_tol});

  // control and side fields down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CMP_LAT-2:0], ent_vld};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0]     <= ent_idx;
    ext_r[0]     <= (ent.extent > cand.extent) ? ent.extent : cand.extent;
    wt_r[0]      <= (ent.weight > cand.weight) ? ent.weight : cand.weight;
    kind_ok_r[0] <= (ent.kind == cand.kind);
    rad_ok_r[0]  <= (rdiff <= rtol_s) && (rdiff >= -rtol_s);
    plane_r[0]   <= (cand.kind == KIND_PLANE);
    for (int i = 1; i < CMP_LAT; i++) begin
      idx_r[i]     <= idx_r[i-1];
      ext_r[i]     <= ext_r[i-1];
      wt_r[i]      <= wt_r[i-1];
      kind_ok_r[i] <= kind_ok_r[i-1];
      rad_ok_r[i]  <= rad_ok_r[i-1];
      plane_r[i]   <= plane_r[i-1];
    end
  end

  // stage 1: origin difference, entry direction
  always_ff @(posedge clk) begin
    dx_r <= $signed({cand.org.x[31], cand.org.x}) - $signed({ent.org.x[31], ent.org.x});
    dy_r <= $signed({cand.org.y[31], cand.org.y}) - $signed({ent.org.y[31], ent.org.y});
    dz_r <= $signed({cand.org.z[31], cand.org.z}) - $signed({ent.org.z[31], ent.org.z});
    ed_r <= ent.dir;
  end

  // stage 2: cross, plane and direction products
  always_ff @(posedge clk) begin
    p_yz_r <= dy_r * ed_r.z;
    p_zy_r <= dz_r * ed_r.y;
    p_zx_r <= dz_r * ed_r.x;
    p_xz_r <= dx_r * ed_r.z;
    p_xy_r <= dx_r * ed_r.y;
    p_yx_r <= dy_r * ed_r.x;
    p_xx_r <= dx_r * ed_r.x;
    p_yy_r <= dy_r * ed_r.y;
    p_zz_r <= dz_r * ed_r.z;
    q_x_r  <= ed_r.x * cand.dir.x;
    q_y_r  <= ed_r.y * cand.dir.y;
    q_z_r  <= ed_r.z * cand.dir.z;
  end

  // stage 3: exact sums floored to 1/1024 mm or Q30
  assign cs0 = 66'(p_yz_r) - 66'(p_zy_r);
  assign cs1 = 66'(p_zx_r) - 66'(p_xz_r);
  assign cs2 = 66'(p_xy_r) - 66'(p_yx_r);
  assign ps  = 67'(p_xx_r) + 67'(p_yy_r) + 67'(p_zz_r);
  assign ds  = 66'(q_x_r) + 66'(q_y_r) + 66'(q_z_r);

  always_ff @(posedge clk) begin
    c0_r <= cs0[65:30];
    c1_r <= cs1[65:30];
    c2_r <= cs2[65:30];
    pd_r <= ps[66:30];
    dd_r <= ds[65:30];
  end

  // stage 4: per-component bounds, squares, direction test
  assign atol_s = $signed({17'b0, tol.axis_tol});
  assign dtol_s = $signed({7'b0, tol.dir_tol});
  assign ca0    = c0_r[35] ? -c0_r : c0_r;
  assign ca1    = c1_r[35] ? -c1_r : c1_r;
  assign ca2    = c2_r[35] ? -c2_r : c2_r;
  assign dabs   = dd_r[35] ? -dd_r : dd_r;
  assign ddiff  = 37'(dabs) - 37'(ONE_Q30);

  always_ff @(posedge clk) begin
    c_ok_r     <= (c0_r <= atol_s) && (c0_r >= -atol_s) &&
                  (c1_r <= atol_s) && (c1_r >= -atol_s) &&
                  (c2_r <= atol_s) && (c2_r >= -atol_s);
    plane_ok_r <= (pd_r <= atol_s) && (pd_r >= -atol_s);
    dir_ok_r   <= (ddiff <= dtol_s) && (ddiff >= -dtol_s);
    sq0_r      <= ca0[19:0] * ca0[19:0];
    sq1_r      <= ca1[19:0] * ca1[19:0];
    sq2_r      <= ca2[19:0] * ca2[19:0];
    tol2_r     <= tol.axis_tol * tol.axis_tol;
  end

  // stage 5: squared line distance and final decision
  assign sq_sum = 42'(sq0_r) + 42'(sq1_r) + 42'(sq2_r);

  always_ff @(posedge clk) begin
    hit_r <= kind_ok_r[3] && dir_ok_r &&
             (plane_r[3] ? plane_ok_r
                         : (rad_ok_r[3] && c_ok_r && (sq_sum <= 42'(tol2_r))));
  end

  assign res.vld    = vld_r[CMP_LAT-1];
  assign res.hit    = hit_r;
  assign res.extent = ext_r[CMP_LAT-1];
  assign res.weight = wt_r[CMP_LAT-1];
  assign res_idx    = idx_r[CMP_LAT-1];

endmodule

### rtl/geometric_feature_merge_table.sv
// Feature merge table. The table is a ring of MAX_FEATURES cells that rotates
// once per offered candidate, so that every entry passes the single compare
// pipeline at the head in table order, one entry per clock. An offer takes
// one full turn of the ring, the five-stage compare pipeline and a write back
// in the done state, independent of the fill level. A clear goes from
// acceptance straight to the done state. A new item is taken only in the idle
// state, so one item is in flight at a time. A new item is accepted while the
// previous result is still waiting on out_tready; the block stalls only in its
// done state if that result has not been taken. Configuration writes are always
// accepted.
module geometric_feature_merge_table #(
  parameter int unsigned MAX_FEATURES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // input transactions
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, radius, extent,
  //        weight, zero fill
  input  logic [263:0] in_tdata,
  // tuser: func, kind
  input  logic [1:0]   in_tuser,
  // result transactions
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: merged, dropped, entry_index, entry_count, entry_extent,
  //        entry_weight, zero fill
  output logic [55:0]  out_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import gfm_pkg::*;

  localparam int unsigned IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int unsigned LAT_W = $clog2(CMP_LAT);

  state_t state_r, state_nxt;

  tol_t             tol_r;
  entry_t           cand_r;
  logic             clr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [LAT_W-1:0] drain_r, drain_nxt;
  logic             found_r;
  logic [IDX_W-1:0] midx_r;
  logic [30:0]      mext_r;
  logic [7:0]       mwt_r;
  logic             out_valid_r;
  logic [55:0]      out_data_r, out_data_nxt;

  logic             in_acc, out_free, finish, shift_en, do_append, do_update;
  entry_t           in_ent;
  entry_t           ring [MAX_FEATURES];
  cmp_res_t         res;
  logic [IDX_W-1:0] res_idx;
  logic             scan_vld;

  // canonical direction
  logic signed [31:0] rdx, rdy, rdz;
  logic signed [32:0] ax, ay, az, nx, ny, nz;
  logic               rev;
  vec3_t              cdir;

  // wide index and count, masked to the result widths
  logic [IDX_W+5:0] idx_w;
  logic [CNT_W+6:0] cnt_w;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r.radius_tol <= RADIUS_TOL_RST;
      tol_r.axis_tol   <= AXIS_TOL_RST;
      tol_r.dir_tol    <= DIR_TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS_TOL: tol_r.radius_tol <= cfg_data[19:0];
        REG_AXIS_TOL:   tol_r.axis_tol   <= cfg_data[19:0];
        REG_DIR_TOL:    tol_r.dir_tol    <= cfg_data;
        default: ;
      endcase
    end
  end

  // direction made canonical: largest component positive, zero becomes +z
  assign rdx = in_tdata[127:96];
  assign rdy = in_tdata[159:128];
  assign rdz = in_tdata[191:160];
  assign ax  = rdx[31] ? -33'(rdx) : 33'(rdx);
  assign ay  = rdy[31] ? -33'(rdy) : 33'(rdy);
  assign az  = rdz[31] ? -33'(rdz) : 33'(rdz);
  assign nx  = -33'(rdx);
  assign ny  = -33'(rdy);
  assign nz  = -33'(rdz);

  always_comb begin
    if (ax >= ay && ax >= az) begin
      rev = rdx[31];
    end else if (ay >= az) begin
      rev = rdy[31];
    end else begin
      rev = rdz[31];
    end
    if (rdx == '0 && rdy == '0 && rdz == '0) begin
      cdir.x = '0;
      cdir.y = '0;
      cdir.z = ONE_Q30;
    end else if (rev) begin
      cdir.x = (nx > MAX_POS_S32) ? MAX_POS_S32[31:0] : nx[31:0];
      cdir.y = (ny > MAX_POS_S32) ? MAX_POS_S32[31:0] : ny[31:0];
      cdir.z = (nz > MAX_POS_S32) ? MAX_POS_S32[31:0] : nz[31:0];
    end else begin
      cdir.x = rdx;
      cdir.y = rdy;
      cdir.z = rdz;
    end
  end

  // candidate unpacked from the input transaction
  always_comb begin
    in_ent.kind   = in_tuser[1];
    in_ent.org.x  = in_tdata[31:0];
    in_ent.org.y  = in_tdata[63:32];
    in_ent.org.z  = in_tdata[95:64];
    in_ent.dir    = cdir;
    in_ent.radius = in_tdata[222:192];
    in_ent.extent = in_tdata[253:223];
    in_ent.weight = in_tdata[261:254];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cand_r <= in_ent;
      clr_r  <= (in_tuser[0] == FUNC_CLEAR);
    end
  end

  // feature ring, cell 0 is the head
  for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
    gfm_cell u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .shift_in   (ring[(i + 1) % MAX_FEATURES]),
      .load_en    (do_append && (cnt_r == CNT_W'(i))),
      .load_val   (cand_r),
      .upd_en     (do_update && (midx_r == IDX_W'(i))),
      .upd_extent (mext_r),
      .upd_weight (mwt_r),
      .q          (ring[i])
    );
  end

  assign scan_vld = (state_r == ST_SCAN) && (CNT_W'(scan_r) < cnt_r);

  gfm_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cand    (cand_r),
    .tol     (tol_r),
    .ent_vld (scan_vld),
    .ent_idx (scan_r),
    .ent     (ring[0]),
    .res     (res),
    .res_idx (res_idx)
  );

  // first match in table order
  always_ff @(posedge clk) begin
    if (!rst_n || in_acc) begin
      found_r <= 1'b0;
    end else if (res.vld && res.hit && !found_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && res.hit && !found_r) begin
      midx_r <= res_idx;
      mext_r <= res.extent;
      mwt_r  <= res.weight;
    end
  end

  // state register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      scan_r  <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      scan_r  <= scan_nxt;
      drain_r <= drain_nxt;
    end
  end

  // next state, counters and result
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_nxt     = scan_r;
    drain_nxt    = drain_r;
    shift_en     = 1'b0;
    finish       = 1'b0;
    do_append    = 1'b0;
    do_update    = 1'b0;
    out_data_nxt = '0;
    idx_w        = '0;
    cnt_w        = '0;
    case (state_r)
      ST_IDLE: begin
        scan_nxt  = '0;
        drain_nxt = '0;
        if (in_acc) begin
          state_nxt = (in_tuser[0] == FUNC_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift_en = 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == IDX_W'(MAX_FEATURES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == LAT_W'(CMP_LAT - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
          if (clr_r) begin
            cnt_nxt = '0;
          end else if (found_r) begin
            do_update          = 1'b1;
            out_data_nxt[0]    = 1'b1;
            out_data_nxt[45:15] = mext_r;
            out_data_nxt[53:46] = mwt_r;
          end else if (cnt_r >= CNT_W'(MAX_FEATURES)) begin
            out_data_nxt[1] = 1'b1;
          end else begin
            do_append           = 1'b1;
            cnt_nxt             = cnt_r + 1'b1;
            out_data_nxt[45:15] = cand_r.extent;
            out_data_nxt[53:46] = cand_r.weight;
          end
          idx_w = do_update ? {6'b0, midx_r} : {6'b0, cnt_r[IDX_W-1:0]};
          cnt_w = {7'b0, cnt_nxt};
          if (!clr_r) begin
            out_data_nxt[14:8] = cnt_w[6:0];
            if (do_update || do_append) begin
              out_data_nxt[7:2] = idx_w[5:0];
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/gfm_checker.sv
// Port-level checks for the geometric feature merge table.
// Sees only the top-level ports; bound to geometric_feature_merge_table.
// Depends on nothing else.
module gfm_checker #(
  parameter int unsigned MAX_FEATURES = 64
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [55:0]  out_tdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in flight: no back-to-back acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  // merged and dropped exclude each other
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("merged and dropped both set");

  // fill level never exceeds the table size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:8] <= 7'(MAX_FEATURES))
    else $error("entry count beyond table size");

  // a merged entry lies inside the filled part of the table
  a_merge_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> {1'b0, out_tdata[7:2]} < out_tdata[14:8])
    else $error("merged index outside table fill");

endmodule

bind geometric_feature_merge_table gfm_checker #(
  .MAX_FEATURES (MAX_FEATURES)
) u_gfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
